@@ rtl/utf8_text_validator_defines.svh @@
// assertion macros for the utf8 text validator checker
// no dependencies; take in by include where assertions are written
`ifndef UTF8_TEXT_VALIDATOR_DEFINES_SVH
`define UTF8_TEXT_VALIDATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define UTF8V_ASSERT_IMPLY(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("utf8v assertion failed");

// next-cycle implication, disabled while reset is low
`define UTF8V_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("utf8v assertion failed");

`endif

@@ rtl/utf8v_pkg.sv @@
// types, constants and helper functions of the utf8 text validator
// no dependencies; used by the interfaces and all modules but utf8v_checker
`default_nettype none

package utf8v_pkg;

  localparam int unsigned MaxLenW = 24;
  localparam int unsigned CountW  = 25;
  localparam int unsigned CpW     = 21;

  localparam logic [MaxLenW-1:0] MaxLenReset = 24'd65536;
  localparam logic [CountW-1:0]  CountCap    = 25'h1000000;

  localparam logic [CpW-1:0] CpMin3  = 21'h000800;
  localparam logic [CpW-1:0] CpMin4  = 21'h010000;
  localparam logic [CpW-1:0] CpSurLo = 21'h00d800;
  localparam logic [CpW-1:0] CpSurHi = 21'h00dfff;
  localparam logic [CpW-1:0] CpMax   = 21'h10ffff;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_NUL       = 4'd1,
    ERR_LEAD      = 4'd2,
    ERR_CONT      = 4'd3,
    ERR_OVERLONG  = 4'd4,
    ERR_SURROGATE = 4'd5,
    ERR_ABOVE     = 4'd6,
    ERR_TRUNC     = 4'd7,
    ERR_LONG      = 4'd8
  } err_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        pend;
    logic [1:0]        seq_len;
    logic [CpW-1:0]    acc;
    err_e              err;
    logic [CountW-1:0] count;
  } text_state_t;

  localparam text_state_t TextClear = '{
    pend: 2'd0, seq_len: 2'd0, acc: '0, err: ERR_NONE, count: '0
  };

  // range check once the last continuation byte of a sequence is in
  function automatic err_e range_error(logic [1:0] seq_len, logic [CpW-1:0] cp);
    err_e res;
    res = ERR_NONE;
    if ((seq_len == 2'd2 && cp < CpMin3) || (seq_len == 2'd3 && cp < CpMin4)) begin
      res = ERR_OVERLONG;
    end else if (cp >= CpSurLo && cp <= CpSurHi) begin
      res = ERR_SURROGATE;
    end else if (cp > CpMax) begin
      res = ERR_ABOVE;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ rtl/utf8v_if.sv @@
// valid/ready channel interfaces: text bytes in, results out, limit writes
// depends on utf8v_pkg
`default_nettype none

interface utf8v_in_if
  import utf8v_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_text;

  modport source (output valid, output data_byte, output has_byte,
                  output end_of_text, input ready);
  modport sink   (input valid, input data_byte, input has_byte,
                  input end_of_text, output ready);
endinterface

interface utf8v_out_if
  import utf8v_pkg::*;
  ();
  logic       valid;
  logic       ready;
  logic       text_valid;
  logic [3:0] error_kind;

  modport source (output valid, output text_valid, output error_kind, input ready);
  modport sink   (input valid, input text_valid, input error_kind, output ready);
endinterface

interface utf8v_cfg_if
  import utf8v_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [MaxLenW-1:0] max_length;

  modport source (output valid, output max_length, input ready);
  modport sink   (input valid, input max_length, output ready);
endinterface

`default_nettype wire

@@ rtl/utf8v_step.sv @@
// per-byte decoder step: next text state and end-of-text result
// depends on utf8v_pkg
`default_nettype none

module utf8v_step
  import utf8v_pkg::*;
(
  input  text_state_t        state_i,
  input  in_item_t           item_i,
  input  logic [MaxLenW-1:0] max_len_i,
  output text_state_t        state_o,
  output err_e               result_o
);

  always_comb begin
    text_state_t    st;
    err_e           res;
    logic [CpW-1:0] cp;
    logic [7:0]     b;
    st  = state_i;
    res = ERR_NONE;
    b   = item_i.data_byte;
    cp  = {state_i.acc[CpW-7:0], b[5:0]};

    if (item_i.has_byte) begin
      if (state_i.count < CountCap) begin
        st.count = state_i.count + CountW'(1);
      end
      if (state_i.err == ERR_NONE) begin
        if (b == 8'h00) begin
          st.err = ERR_NUL;
        end else if (state_i.pend != 2'd0) begin
          if (b[7:6] != 2'b10) begin
            st.err = ERR_CONT;
          end else begin
            st.acc  = cp;
            st.pend = state_i.pend - 2'd1;
            if (state_i.pend == 2'd1) begin
              st.err = range_error(state_i.seq_len, cp);
            end
          end
        end else if (b[7] == 1'b0) begin
          // plain ascii, nothing to track
        end else if (b[7:5] == 3'b110) begin
          if (b[4:1] == 4'd0) begin
            st.err = ERR_LEAD;
          end else begin
            st.seq_len = 2'd1;
            st.pend    = 2'd1;
            st.acc     = {16'd0, b[4:0]};
          end
        end else if (b[7:4] == 4'b1110) begin
          st.seq_len = 2'd2;
          st.pend    = 2'd2;
          st.acc     = {17'd0, b[3:0]};
        end else if (b[7:3] == 5'b11110) begin
          st.seq_len = 2'd3;
          st.pend    = 2'd3;
          st.acc     = {18'd0, b[2:0]};
        end else begin
          st.err = ERR_LEAD;
        end
      end
    end

    if (item_i.end_of_text) begin
      res = st.err;
      if (res == ERR_NONE && st.pend != 2'd0) begin
        res = ERR_TRUNC;
      end
      // length limit overrides any encoding error
      if (st.count > {1'b0, max_len_i}) begin
        res = ERR_LONG;
      end
      st = TextClear;
    end

    state_o  = st;
    result_o = res;
  end

endmodule

`default_nettype wire

@@ rtl/utf8_text_validator.sv @@
// result path: an end request is taken into the input register, its result then into the output register
// throughput: one request per cycle; the input register advances each cycle
// unless an end request waits behind a result that has not been taken
// reset: clears text state, both valid flags, and sets max_length to 65536
// top level of the utf8 text validator; depends on utf8v_pkg, utf8v_if, utf8v_step
`default_nettype none

module utf8_text_validator
  import utf8v_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  utf8v_in_if.sink     in_i,
  utf8v_cfg_if.sink    cfg_i,
  utf8v_out_if.source  out_o
);

  logic               s1_valid_q;
  in_item_t           s1_item_q;
  text_state_t        state_q;
  text_state_t        state_d;
  err_e               result_d;
  logic [MaxLenW-1:0] max_len_q;
  logic               out_valid_q;
  err_e               out_err_q;
  logic               out_free;
  logic               s1_fire;
  logic               in_take;

  assign out_free = !out_valid_q || out_o.ready;
  assign s1_fire  = s1_valid_q && (!s1_item_q.end_of_text || out_free);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_take  = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  utf8v_step u_step (
    .state_i   (state_q),
    .item_i    (s1_item_q),
    .max_len_i (max_len_q),
    .state_o   (state_d),
    .result_o  (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q <= '{data_byte: in_i.data_byte, has_byte: in_i.has_byte,
                     end_of_text: in_i.end_of_text};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= TextClear;
    end else if (s1_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_i.valid) begin
      max_len_q <= cfg_i.max_length;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_item_q.end_of_text) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_item_q.end_of_text) begin
      out_err_q <= result_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.error_kind = 4'(out_err_q);
  assign out_o.text_valid = (out_err_q == ERR_NONE);

endmodule

`default_nettype wire

@@ rtl/utf8v_checker.sv @@
// port-level assertions for the utf8 text validator, bound to the top level
// depends on utf8_text_validator_defines.svh and utf8_text_validator
`default_nettype none
`include "utf8_text_validator_defines.svh"

module utf8v_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_i,
  input wire logic       in_end_i,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       out_text_valid_i,
  input wire logic [3:0] out_error_kind_i
);

  `UTF8V_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)

  `UTF8V_ASSERT_IMPLY(a_flag_match, clk_i, rst_ni, out_valid_i,
    out_text_valid_i == (out_error_kind_i == 4'd0))

  `UTF8V_ASSERT_IMPLY(a_kind_range, clk_i, rst_ni, out_valid_i, out_error_kind_i <= 4'd8)

  `UTF8V_ASSERT_IMPLY(a_ready_when_empty, clk_i, rst_ni, !out_valid_i, in_ready_i)

  `UTF8V_ASSERT_IMPLY(a_result_source, clk_i, rst_ni, $rose(out_valid_i),
    $past(in_valid_i && in_ready_i && in_end_i, 2))

endmodule

bind utf8_text_validator utf8v_checker u_utf8v_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .in_end_i         (in_i.end_of_text),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_text_valid_i (out_o.text_valid),
  .out_error_kind_i (out_o.error_kind)
);

`default_nettype wire

@@ tb/utf8v_text_checker.sv @@
// verdict checker for the utf8 text validator: follows byte and limit requests,
// predicts each text's result and compares it with the result channel
// depends on utf8v_pkg and the channel interfaces of utf8v_if
module utf8v_text_checker
  import utf8v_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  utf8v_in_if  in_i,
  utf8v_cfg_if cfg_i,
  utf8v_out_if out_i,
  output int   fail_cnt_o,
  output int   open_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic ok;
    err_e kind;
  } verdict_t;

  logic [MaxLenW-1:0] len_limit;
  logic [1:0]         cont_left;
  logic [1:0]         cont_total;
  logic [CpW-1:0]     cp_acc;
  err_e               first_err;
  logic [CountW-1:0]  byte_cnt;
  verdict_t           verdict_q[$];
  verdict_t           head;
  int                 mismatch_cnt;

  function automatic void clear_text();
    cont_left  = 2'd0;
    cont_total = 2'd0;
    cp_acc     = '0;
    first_err  = ERR_NONE;
    byte_cnt   = '0;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    if (byte_cnt < CountCap) byte_cnt++;
    // once a text has failed its bytes are only counted
    if (first_err != ERR_NONE) return;
    if (b == 8'h00) begin
      first_err = ERR_NUL;
    end else if (cont_left != 2'd0) begin
      if (b[7:6] != 2'b10) begin
        first_err = ERR_CONT;
      end else begin
        cp_acc = {cp_acc[CpW-7:0], b[5:0]};
        cont_left--;
        if (cont_left == 2'd0) begin
          if ((cont_total == 2'd2 && cp_acc < CpMin3) ||
              (cont_total == 2'd3 && cp_acc < CpMin4)) begin
            first_err = ERR_OVERLONG;
          end else if (cp_acc >= CpSurLo && cp_acc <= CpSurHi) begin
            first_err = ERR_SURROGATE;
          end else if (cp_acc > CpMax) begin
            first_err = ERR_ABOVE;
          end
        end
      end
    end else if (b[7]) begin
      if (b[7:5] == 3'b110) begin
        // c0 and c1 could only start overlong two-byte forms
        if (b[4:1] == 4'd0) begin
          first_err = ERR_LEAD;
        end else begin
          cont_total = 2'd1;
          cp_acc     = {16'd0, b[4:0]};
        end
      end else if (b[7:4] == 4'b1110) begin
        cont_total = 2'd2;
        cp_acc     = {17'd0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
        cont_total = 2'd3;
        cp_acc     = {18'd0, b[2:0]};
      end else begin
        first_err = ERR_LEAD;
      end
      if (first_err == ERR_NONE) cont_left = cont_total;
    end
  endfunction

  function automatic void close_text();
    err_e kind;
    kind = first_err;
    if (kind == ERR_NONE && cont_left != 2'd0) kind = ERR_TRUNC;
    // the length limit overrides any encoding error
    if (byte_cnt > {1'b0, len_limit}) kind = ERR_LONG;
    verdict_q.push_back(verdict_t'{ok: (kind == ERR_NONE), kind: kind});
    clear_text();
  endfunction

  function automatic void note_failure(input bit had_want, input verdict_t want,
                                       input logic got_ok, input logic [3:0] got_kind);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) begin
      if (had_want) begin
        $display("%0t text result mismatch: expected valid=%0b kind=%0d, got valid=%0b kind=%0d",
                 $realtime, want.ok, want.kind, got_ok, got_kind);
      end else begin
        $display("%0t result with no text pending: valid=%0b kind=%0d",
                 $realtime, got_ok, got_kind);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_text();
      len_limit = MaxLenReset;
      verdict_q.delete();
      mismatch_cnt = 0;
      fail_cnt_o <= 0;
      open_cnt_o <= 0;
    end else begin
      if (out_i.valid === 1'b1 && out_i.ready === 1'b1) begin
        if (verdict_q.size() == 0) begin
          note_failure(1'b0, '0, out_i.text_valid, out_i.error_kind);
        end else begin
          head = verdict_q.pop_front();
          if (out_i.text_valid !== head.ok || out_i.error_kind !== head.kind) begin
            note_failure(1'b1, head, out_i.text_valid, out_i.error_kind);
          end
        end
      end
      if (cfg_i.valid === 1'b1 && cfg_i.ready === 1'b1) len_limit = cfg_i.max_length;
      if (in_i.valid === 1'b1 && in_i.ready === 1'b1) begin
        if (in_i.has_byte) absorb_byte(in_i.data_byte);
        if (in_i.end_of_text) close_text();
      end
      fail_cnt_o <= mismatch_cnt;
      open_cnt_o <= verdict_q.size();
    end
  end

endmodule

@@ tb/utf8_text_validator_tb.sv @@
// testbench top of the utf8 text validator: clock, reset, byte and limit stimulus,
// result-side stalls and the verdict; checking is done in utf8v_text_checker
// depends on utf8v_pkg, utf8v_if and the validator rtl
module utf8_text_validator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import utf8v_pkg::*;

  localparam int unsigned ResetCycles  = 9;
  localparam int unsigned PhaseCnt     = 8;
  localparam int unsigned PhaseItems   = 205;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned LimitCycles  = 400_000;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  typedef enum int unsigned {
    FLT_NUL, FLT_JUNK, FLT_OVERLONG, FLT_SURROGATE, FLT_ABOVE,
    FLT_CUT, FLT_BAD_CONT, FLT_STRAY_CONT, FLT_EDGE_CP
  } fault_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_cnt;
  int   open_cnt;

  logic [7:0]  text_buf[$];
  int unsigned burst_left = 0;
  int unsigned items_sent = 0;

  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_hold = 0;
  logic [31:0] rx_tick = '0;

  utf8v_in_if  in_ch ();
  utf8v_cfg_if cfg_ch ();
  utf8v_out_if out_ch ();

  utf8_text_validator u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .cfg_i  (cfg_ch),
    .out_o  (out_ch)
  );

  utf8v_text_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_ch),
    .cfg_i      (cfg_ch),
    .out_i      (out_ch),
    .fail_cnt_o (fail_cnt),
    .open_cnt_o (open_cnt)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side: a stall pattern picked at random from four modes, switched when its hold count runs out
  always @(posedge clk) begin
    if (rx_hold == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_hold = $urandom_range(16, 256);
    end else begin
      rx_hold--;
    end
    rx_tick++;
    case (rx_mode)
      RX_OPEN:  out_ch.ready <= 1'b1;
      RX_LIGHT: out_ch.ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default:  out_ch.ready <= rx_tick[3];
    endcase
  end

  function automatic void add_code_point(input logic [20:0] cp, input int unsigned n);
    case (n)
      1: text_buf.push_back({1'b0, cp[6:0]});
      2: begin
        text_buf.push_back({3'b110, cp[10:6]});
        text_buf.push_back({2'b10, cp[5:0]});
      end
      3: begin
        text_buf.push_back({4'b1110, cp[15:12]});
        text_buf.push_back({2'b10, cp[11:6]});
        text_buf.push_back({2'b10, cp[5:0]});
      end
      default: begin
        text_buf.push_back({5'b11110, cp[20:18]});
        text_buf.push_back({2'b10, cp[17:12]});
        text_buf.push_back({2'b10, cp[11:6]});
        text_buf.push_back({2'b10, cp[5:0]});
      end
    endcase
  endfunction

  // well-formed character of n bytes, n from 2 to 4
  function automatic void add_multibyte(input int unsigned n);
    logic [20:0] cp;
    if (n == 2) begin
      cp = 21'($urandom_range('h80, 'h7ff));
    end else if (n == 3) begin
      cp = 21'($urandom_range('h800, 'hf7ff));
      if (cp >= CpSurLo) cp += 21'h800;
    end else begin
      cp = 21'($urandom_range('h10000, 'h10ffff));
    end
    add_code_point(cp, n);
  endfunction

  function automatic void add_char();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 8) begin
      add_code_point(21'($urandom_range(1, 'h7f)), 1);
    end else if (pick < 12) begin
      add_multibyte(2);
    end else if (pick < 17) begin
      add_multibyte(3);
    end else begin
      add_multibyte(4);
    end
  endfunction

  function automatic void add_fault();
    fault_e      f;
    int unsigned n;
    int unsigned k;
    logic [7:0]  junk;
    logic [20:0] cp;
    f = fault_e'($urandom_range(0, 8));
    case (f)
      FLT_NUL:  text_buf.push_back(8'h00);
      FLT_JUNK: text_buf.push_back(8'($urandom_range(0, 255)));
      FLT_OVERLONG: begin
        n = $urandom_range(2, 4);
        if (n == 2) cp = 21'($urandom_range(0, 'h7f));
        else if (n == 3) cp = 21'($urandom_range(0, 'h7ff));
        else cp = 21'($urandom_range(0, 'hffff));
        add_code_point(cp, n);
      end
      FLT_SURROGATE: add_code_point(21'($urandom_range(CpSurLo, CpSurHi)), 3);
      // covers f4 90.. as well as the f5..f7 leads
      FLT_ABOVE: add_code_point(21'($urandom_range('h110000, 'h1fffff)), 4);
      FLT_CUT: begin
        n = $urandom_range(2, 4);
        add_multibyte(n);
        k = $urandom_range(1, n - 1);
        repeat (k) void'(text_buf.pop_back());
      end
      FLT_BAD_CONT: begin
        n = $urandom_range(2, 4);
        add_multibyte(n);
        k = text_buf.size() - $urandom_range(1, n - 1);
        junk = 8'($urandom_range(0, 255));
        if (junk[7:6] == 2'b10) junk[6] = 1'b1;
        text_buf[k] = junk;
      end
      FLT_STRAY_CONT: text_buf.push_back({2'b10, 6'($urandom_range(0, 63))});
      default: begin
        // valid code points right at the range boundaries
        case ($urandom_range(0, 8))
          0: add_code_point(21'h00007f, 1);
          1: add_code_point(21'h000080, 2);
          2: add_code_point(21'h0007ff, 2);
          3: add_code_point(21'h000800, 3);
          4: add_code_point(21'h00d7ff, 3);
          5: add_code_point(21'h00e000, 3);
          6: add_code_point(21'h00ffff, 3);
          7: add_code_point(21'h010000, 4);
          default: add_code_point(21'h10ffff, 4);
        endcase
      end
    endcase
  endfunction

  function automatic void make_text(input int unsigned max_chars);
    int unsigned nchar;
    int unsigned fault_at;
    bit          broken;
    text_buf.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 8)) text_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      nchar = $urandom_range(0, max_chars);
      broken = ($urandom_range(0, 3) == 0);
      fault_at = $urandom_range(0, nchar);
      for (int unsigned i = 0; i <= nchar; i++) begin
        if (broken && i == fault_at) add_fault();
        if (i < nchar) add_char();
      end
    end
  endfunction

  task automatic put_item(input logic [7:0] b, input logic has, input logic eot);
    int unsigned gap;
    int unsigned gap_pick;
    if (burst_left == 0) begin
      gap_pick = $urandom_range(0, 9);
      if (gap_pick < 4) gap = 0;
      else if (gap_pick < 9) gap = $urandom_range(1, 5);
      else gap = $urandom_range(8, 20);
      burst_left = $urandom_range(1, 48);
      if (gap != 0) begin
        in_ch.valid       <= 1'b0;
        in_ch.data_byte   <= 8'($urandom_range(0, 255));
        in_ch.has_byte    <= 1'($urandom_range(0, 1));
        in_ch.end_of_text <= 1'($urandom_range(0, 1));
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= b;
    in_ch.has_byte    <= has;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (has || eot) items_sent++;
  endtask

  task automatic send_text(input bit join_end, input bit with_idles);
    int unsigned n;
    n = text_buf.size();
    for (int unsigned i = 0; i < n; i++) begin
      if (with_idles && $urandom_range(0, 15) == 0) begin
        put_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      put_item(text_buf[i], 1'b1, join_end && (i == n - 1));
    end
    if (!join_end || n == 0) put_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // lets every outstanding text finish before the limit changes
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (open_cnt != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_limit(input logic [MaxLenW-1:0] lim);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.max_length <= lim;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    repeat (LimitCycles) @(posedge clk);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [MaxLenW-1:0] lim;
    int unsigned        goal;
    int unsigned        max_chars;
    in_ch.valid       <= 1'b0;
    in_ch.data_byte   <= 8'h00;
    in_ch.has_byte    <= 1'b0;
    in_ch.end_of_text <= 1'b0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.max_length <= '0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    // directed texts under the reset limit
    text_buf.delete();
    send_text(1'b1, 1'b0);                      // empty text
    put_item(8'ha5, 1'b0, 1'b0);                // idle request
    text_buf = '{8'h00};
    send_text(1'b1, 1'b0);
    text_buf = '{8'hc0};
    send_text(1'b1, 1'b0);
    text_buf = '{8'hc2, 8'h41};
    send_text(1'b1, 1'b0);
    text_buf = '{8'he0, 8'h80, 8'h80};
    send_text(1'b1, 1'b0);
    text_buf = '{8'hed, 8'ha0, 8'h80};
    send_text(1'b1, 1'b0);
    text_buf = '{8'hf4, 8'h90, 8'h80, 8'h80};
    send_text(1'b1, 1'b0);
    text_buf = '{8'he2};
    send_text(1'b0, 1'b0);                      // cut off by a separate end
    text_buf = '{8'hff, 8'h00};
    send_text(1'b1, 1'b0);                      // nul after an error is ignored
    text_buf = '{8'hc2, 8'h00};
    send_text(1'b1, 1'b0);                      // nul in continuation position
    text_buf = '{8'hf4, 8'h8f, 8'hbf, 8'hbf};
    send_text(1'b1, 1'b0);

    for (int unsigned ph = 0; ph < PhaseCnt; ph++) begin
      wait_drained();
      case (ph)
        0: lim = '0;
        1: lim = '1;
        2: lim = MaxLenW'($urandom_range(1, 4));
        7: lim = MaxLenW'($urandom_range(41, 200));
        default: lim = MaxLenW'($urandom_range(5, 40));
      endcase
      write_limit(lim);
      // for limits under 40, keep text lengths around the limit so both sides of it are hit
      max_chars = (lim < 40) ? lim / 2 + 3 : 12;
      goal = items_sent + PhaseItems;
      while (items_sent < goal) begin
        make_text(max_chars);
        send_text(1'($urandom_range(0, 1)), 1'b1);
      end
    end

    wait_drained();
    if (fail_cnt == 0 && open_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ utf8_text_validator.f @@
+incdir+rtl
rtl/utf8v_pkg.sv
rtl/utf8v_if.sv
rtl/utf8v_step.sv
rtl/utf8_text_validator.sv
rtl/utf8v_checker.sv
tb/utf8v_text_checker.sv
tb/utf8_text_validator_tb.sv
